// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define MHEAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MHEAD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mhead_pkg.sv =====
// types, angle constants and arctangent table for the heading pipeline
package mhead_pkg;

  // datapath widths
  localparam int CORD_W = 27;
  localparam int ANG_W  = 22;
  localparam int HDG_W  = 13;
  localparam int OFS_W  = 9;
  localparam int TAB_LEN = 24;

  typedef logic signed [CORD_W-1:0] cord_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic [HDG_W-1:0]         hdg_t;
  typedef logic [OFS_W-1:0]         ofs_t;

  // angles in 1/4096 degree
  localparam ang_t ANG_180 = 22'sd737280;
  localparam logic signed [ANG_W:0] ANG_360_S = 23'sd1474560;
  localparam logic [ANG_W-2:0] ANG_360_U = 21'd1474560;
  localparam logic [ANG_W-2:0] ANG_HALF_LSB = 21'd128;

  // headings in 1/16 degree
  localparam hdg_t H_90  = 13'd1440;
  localparam hdg_t H_180 = 13'd2880;
  localparam hdg_t H_270 = 13'd4320;
  localparam hdg_t H_360 = 13'd5760;
  localparam logic [HDG_W:0] TURN_DEG16 = 14'd5760;

  // atan(2^-i) in 1/4096 degree, rounded to nearest
  localparam ang_t ATAN_TAB [TAB_LEN] = '{
    22'sd184320, 22'sd108810, 22'sd57492, 22'sd29184,
    22'sd14649,  22'sd7331,   22'sd3667,  22'sd1833,
    22'sd917,    22'sd458,    22'sd229,   22'sd115,
    22'sd57,     22'sd29,     22'sd14,    22'sd7,
    22'sd4,      22'sd2,      22'sd1,     22'sd0,
    22'sd0,      22'sd0,      22'sd0,     22'sd0
  };

  // one request on its way through the rotation stages
  typedef struct packed {
    cord_t x;
    cord_t y;
    ang_t  z;
    logic  y_neg;
    logic  special;
    hdg_t  h_special;
  } cordic_t;

endpackage

// ===== hw/rtl/magnetometer_heading_unit.sv =====
// Compass heading from one magnetometer sample per request.
// Input channel (in_valid/in_ready): the high and low bytes of the signed
// 16-bit X and Y readings. Result channel (out_valid/out_ready): the heading
// in 1/16 degree, 0 to 360 degrees plus the mounting offset, wrapped once.
// Configuration: cfg_wr_en writes cfg_wr_data into the mounting offset in
// whole degrees, taking effect on requests that reach the last stage; write it
// only while the pipeline is empty.
// From acceptance to out_valid a request passes one input stage, one stage per
// rotation step and two output stages.
// Throughput is one request per cycle while the output is not stalled; every
// stage, each rotation step included, holds one request.
// The whole pipeline advances together; when out_valid is high and out_ready
// low every stage holds, in_ready drops, and nothing is lost or repeated.
// Bubbles are not squeezed out during a stall.
// Synchronous reset clears every valid bit and loads an offset of 33 degrees.
module magnetometer_heading_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_x_msb,
  input  logic [7:0]             in_x_lsb,
  input  logic [7:0]             in_y_msb,
  input  logic [7:0]             in_y_lsb,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [12:0]            out_heading_deg16,
  input  logic                   cfg_wr_en,
  input  logic [8:0]             cfg_wr_data
);
  import mhead_pkg::*;

  logic    adv;
  ofs_t    offset_r;
  logic    stg_valid [CORDIC_STEPS+1];
  cordic_t stg_d     [CORDIC_STEPS+1];

  // global stall from the output register
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 9'd33;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  mhead_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_x_msb  (in_x_msb),
    .in_x_lsb  (in_x_lsb),
    .in_y_msb  (in_y_msb),
    .in_y_lsb  (in_y_lsb),
    .out_valid (stg_valid[0]),
    .out_d     (stg_d[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    mhead_cordic_stage #(.STAGE_IDX(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stg_valid[i]),
      .in_d      (stg_d[i]),
      .out_valid (stg_valid[i+1]),
      .out_d     (stg_d[i+1])
    );
  end

  mhead_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (stg_valid[CORDIC_STEPS]),
    .in_d        (stg_d[CORDIC_STEPS]),
    .offset      (offset_r),
    .out_valid   (out_valid),
    .out_heading (out_heading_deg16)
  );
endmodule

// ===== hw/rtl/mhead_prep.sv =====
// input stage: joins the axis bytes, flags the axis cases and pre-rotates into the right half-plane
module mhead_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [7:0]           in_x_msb,
  input  logic [7:0]           in_x_lsb,
  input  logic [7:0]           in_y_msb,
  input  logic [7:0]           in_y_lsb,
  output logic                 out_valid,
  output mhead_pkg::cordic_t   out_d
);
  import mhead_pkg::*;

  logic signed [15:0] x16;
  logic signed [15:0] y16;
  cord_t   cx;
  cord_t   cy;
  cordic_t d_nxt;
  cordic_t d_r;
  logic    valid_r;

  assign x16 = $signed({in_x_msb, in_x_lsb});
  assign y16 = $signed({in_y_msb, in_y_lsb});
  assign cx  = $signed({{(CORD_W-24){x16[15]}}, x16, 8'h00});
  assign cy  = $signed({{(CORD_W-24){y16[15]}}, y16, 8'h00});

  always_comb begin
    d_nxt.y_neg   = y16[15];
    d_nxt.special = (y16 == 16'sd0) || (x16 == 16'sd0);
    if (y16 == 16'sd0) begin
      d_nxt.h_special = x16[15] ? H_180 : H_360;
    end else begin
      d_nxt.h_special = y16[15] ? H_270 : H_90;
    end
    // left half-plane: rotate by half a turn first
    if (x16[15]) begin
      d_nxt.x = -cx;
      d_nxt.y = -cy;
      d_nxt.z = y16[15] ? -ANG_180 : ANG_180;
    end else begin
      d_nxt.x = cx;
      d_nxt.y = cy;
      d_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
endmodule

// ===== hw/rtl/mhead_cordic_stage.sv =====
// one registered vectoring step of the rotation pipeline
module mhead_cordic_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  mhead_pkg::cordic_t   in_d,
  output logic                 out_valid,
  output mhead_pkg::cordic_t   out_d
);
  import mhead_pkg::*;

  cord_t   dx;
  cord_t   dy;
  cordic_t d_nxt;
  cordic_t d_r;
  logic    valid_r;

  assign dx = in_d.y >>> STAGE_IDX;
  assign dy = in_d.x >>> STAGE_IDX;

  always_comb begin
    d_nxt = in_d;
    // drive y towards zero
    if (!in_d.y[CORD_W-1]) begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + ATAN_TAB[STAGE_IDX];
    end else begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - ATAN_TAB[STAGE_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
endmodule

// ===== hw/rtl/mhead_post.sv =====
// output stages: full-turn wrap, clamp and rounding, then the mounting offset
module mhead_post (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  mhead_pkg::cordic_t   in_d,
  input  mhead_pkg::ofs_t      offset,
  output logic                 out_valid,
  output mhead_pkg::hdg_t      out_heading
);
  import mhead_pkg::*;

  logic signed [ANG_W:0] zw;
  logic [ANG_W-2:0]      zc;
  logic [ANG_W-2:0]      zr;
  hdg_t                  h_nxt;
  hdg_t                  h_r;
  logic                  h_valid_r;
  logic [HDG_W:0]        sum;
  hdg_t                  hdg_nxt;
  hdg_t                  hdg_r;
  logic                  hdg_valid_r;

  always_comb begin
    zw = {in_d.z[ANG_W-1], in_d.z} + (in_d.y_neg ? ANG_360_S : '0);
    if (zw[ANG_W]) begin
      zc = '0;
    end else if (zw[ANG_W-2:0] > ANG_360_U || zw[ANG_W-1]) begin
      zc = ANG_360_U;
    end else begin
      zc = zw[ANG_W-2:0];
    end
    // round half up to 1/16 degree
    zr    = zc + ANG_HALF_LSB;
    h_nxt = in_d.special ? in_d.h_special : zr[ANG_W-2:8];
  end

  always_comb begin
    sum = {1'b0, h_r} + {1'b0, offset, 4'h0};
    if (sum > TURN_DEG16) begin
      hdg_nxt = HDG_W'(sum - TURN_DEG16);
    end else begin
      hdg_nxt = sum[HDG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r   <= 1'b0;
      hdg_valid_r <= 1'b0;
    end else if (adv) begin
      h_valid_r   <= in_valid;
      hdg_valid_r <= h_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      h_r <= h_nxt;
    end
    if (adv && h_valid_r) begin
      hdg_r <= hdg_nxt;
    end
  end

  assign out_valid   = hdg_valid_r;
  assign out_heading = hdg_r;
endmodule

// ===== hw/rtl/mhead_checker.sv =====
// port-level checks for the heading unit and their binding
`include "assert_macros.svh"

module mhead_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_heading_deg16
);
  `MHEAD_ASSERT(a_hold_on_stall, out_valid && !out_ready |=> out_valid && $stable(out_heading_deg16), "result changed while stalled")
  `MHEAD_ASSERT(a_ready_tracks_stall, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")
  `MHEAD_ASSERT(a_no_accept_in_stall, out_valid && !out_ready |-> !(in_valid && in_ready), "request taken during stall")
  `MHEAD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind magnetometer_heading_unit mhead_checker u_mhead_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_heading_deg16 (out_heading_deg16)
);

// ===== verif/heading_checker.sv =====
// channel monitor, heading predictor and result comparison for the heading unit
`timescale 1ns / 1ps

module heading_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_x_msb,
  input  logic [7:0]           in_x_lsb,
  input  logic [7:0]           in_y_msb,
  input  logic [7:0]           in_y_lsb,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  mhead_pkg::hdg_t      out_heading_deg16,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_wr_data,
  output int unsigned          fault_count,
  output int unsigned          backlog
);

  localparam int unsigned ROT_LIMIT = 24;
  localparam longint DEG = 4096;
  localparam longint HALF_TURN = 180 * DEG;
  localparam longint FULL_TURN = 360 * DEG;
  localparam longint FULL_TURN_H = 5760;
  localparam int unsigned REPORT_MAX = 10;

  // arctangent of 2^-i in 1/4096 degree
  localparam longint ROT_ANGLE [ROT_LIMIT] = '{
    184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [15:0]     x_word;
    logic [15:0]     y_word;
    logic [8:0]      offset;
    mhead_pkg::hdg_t heading;
  } heading_due_t;

  heading_due_t heading_due [$];
  logic [8:0]   mount_offset;

  function automatic mhead_pkg::hdg_t predict_heading(logic [15:0] x_word,
                                                      logic [15:0] y_word,
                                                      logic [8:0] offset);
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    longint x, y, cx, cy, dx, dy, z, h;
    xs = x_word;
    ys = y_word;
    x = xs;
    y = ys;
    if (y == 0) begin
      z = (x >= 0) ? FULL_TURN : HALF_TURN;
    end else if (x == 0) begin
      z = (y > 0) ? 90 * DEG : 270 * DEG;
    end else begin
      cx = x * 256;
      cy = y * 256;
      z = 0;
      // left half plane: rotate by half a turn first
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z = (y > 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STEPS && i < ROT_LIMIT; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z += ROT_ANGLE[i];
        end else begin
          cx -= dx;
          cy += dy;
          z -= ROT_ANGLE[i];
        end
      end
      // the turn is added on the sign of y, not on the residue
      if (y < 0) z += FULL_TURN;
      if (z < 0) z = 0;
      if (z > FULL_TURN) z = FULL_TURN;
    end
    h = (z + 128) >>> 8;
    h += longint'(offset) * 16;
    if (h > FULL_TURN_H) h -= FULL_TURN_H;
    return h[12:0];
  endfunction

  always @(posedge clk) begin
    heading_due_t head;
    if (!rst_n) begin
      mount_offset = 9'd33;
    end else begin
      if (cfg_wr_en) mount_offset = cfg_wr_data;
      if (in_valid && in_ready) begin
        head.x_word = {in_x_msb, in_x_lsb};
        head.y_word = {in_y_msb, in_y_lsb};
        head.offset = mount_offset;
        head.heading = predict_heading(head.x_word, head.y_word, mount_offset);
        heading_due.push_back(head);
      end
      if (out_valid && out_ready) begin
        if (heading_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("heading result %0d with no request outstanding", out_heading_deg16);
        end else begin
          head = heading_due.pop_front();
          if (out_heading_deg16 !== head.heading) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("heading mismatch x=%h y=%h offset=%0d: expected %0d, got %0d",
                       head.x_word, head.y_word, head.offset, head.heading,
                       out_heading_deg16);
          end
        end
      end
    end
    backlog = heading_due.size();
  end

  initial begin
    fault_count = 0;
    backlog = 0;
    mount_offset = 9'd33;
  end

endmodule

// ===== verif/magnetometer_heading_unit_tb.sv =====
// stimulus, offset phases and verdict for the magnetometer heading unit
`timescale 1ns / 1ps

module magnetometer_heading_unit_tb;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = STEPS + 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT = 38;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_x_msb = '0;
  logic [7:0]      in_x_lsb = '0;
  logic [7:0]      in_y_msb = '0;
  logic [7:0]      in_y_lsb = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  mhead_pkg::hdg_t out_heading_deg16;
  logic            cfg_wr_en = 1'b0;
  logic [8:0]      cfg_wr_data = '0;
  int unsigned     fault_count;
  int unsigned     backlog;
  bit              no_idle = 1'b0;
  int unsigned     cycle_count = 0;

  // x and y words of the directed requests
  localparam logic [31:0] CORNER [23] = '{
    32'h0000_0000, 32'h1234_0000, 32'h8000_0000, 32'hFFFF_0000,
    32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF,
    32'h7FFF_0001, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_FFFF,
    32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
    32'h0001_0001, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF_0001,
    32'h00FF_FF00, 32'hFF00_00FF, 32'h5A5A_A5A5
  };

  localparam logic [8:0] OFFSET_STEP [7] = '{
    9'd0, 9'd359, 9'd511, 9'd360, 9'd1, 9'd180, 9'd0
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magnetometer_heading_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_msb          (in_x_msb),
    .in_x_lsb          (in_x_lsb),
    .in_y_msb          (in_y_msb),
    .in_y_lsb          (in_y_lsb),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heading_deg16 (out_heading_deg16),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  heading_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_msb          (in_x_msb),
    .in_x_lsb          (in_x_lsb),
    .in_y_msb          (in_y_msb),
    .in_y_lsb          (in_y_lsb),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heading_deg16 (out_heading_deg16),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fault_count       (fault_count),
    .backlog           (backlog)
  );

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // called on a falling edge, returns on a falling edge
  task automatic send_sample(input logic [15:0] x_word, input logic [15:0] y_word);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_x_msb, in_x_lsb} <= x_word;
    {in_y_msb, in_y_lsb} <= y_word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [15:0] extreme [5];
    logic [15:0] x_word, y_word;
    int unsigned kind;
    extreme = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000};
    kind = $urandom_range(99);
    x_word = 16'($urandom());
    y_word = 16'($urandom());
    if (kind >= 60 && kind < 72) begin
      x_word = 16'($urandom_range(8)) - 16'd4;
      y_word = 16'($urandom_range(8)) - 16'd4;
    end else if (kind >= 72 && kind < 80) begin
      if ($urandom_range(1) == 0) x_word = '0;
      else y_word = '0;
    end else if (kind >= 80 && kind < 88) begin
      x_word = extreme[$urandom_range(4)];
      y_word = extreme[$urandom_range(4)];
    end else if (kind >= 88) begin
      // nearly on the x axis: tiny angles either side of the wrap or of half a turn
      y_word = 16'($urandom_range(6)) - 16'd3;
    end
    return {x_word, y_word};
  endfunction

  task automatic run_random(input int unsigned count);
    logic [31:0] sample;
    repeat (count) begin
      sample = pick_sample();
      send_sample(sample[31:16], sample[15:0]);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_offset(input logic [8:0] offset);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= offset;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset offset of 33 degrees first
    foreach (CORNER[i]) send_sample(CORNER[i][31:16], CORNER[i][15:0]);
    run_random(80);
    for (int p = 0; p < 8; p++) begin
      drain_pipeline();
      write_offset(p < 7 ? OFFSET_STEP[p] : 9'($urandom_range(511)));
      no_idle = (p == 3);
      run_random(65);
    end
    no_idle = 1'b0;
    drain_pipeline();
    repeat (LATENCY) @(negedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
